>>> rtl/lc3s_pkg.sv
// lc3s_pkg: shared types and constants of the lc3 instruction step unit
// no dependencies
package lc3s_pkg;

  localparam logic [2:0] MODE_WMEM = 3'd0;
  localparam logic [2:0] MODE_WREG = 3'd1;
  localparam logic [2:0] MODE_STEP = 3'd2;
  localparam logic [2:0] MODE_RMEM = 3'd3;
  localparam logic [2:0] MODE_RREG = 3'd4;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [7:0] TRAP_HALT = 8'h25;

  localparam logic [2:0] CC_NEG  = 3'd4;
  localparam logic [2:0] CC_ZERO = 3'd2;
  localparam logic [2:0] CC_POS  = 3'd1;

  // memory address source
  localparam logic [1:0] MA_INPUT = 2'd0;
  localparam logic [1:0] MA_PC    = 2'd1;
  localparam logic [1:0] MA_EA    = 2'd2;
  localparam logic [1:0] MA_RDATA = 2'd3;

  typedef struct packed {
    logic       take;      // latch input item
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] mem_sel;
    logic       wr_input;  // write data from the item, else from a register
    logic       ir_load;
    logic       exec;      // execute non-memory part, pc update
    logic       load_wb;   // write loaded word to dr with cc
    logic       ptr_load;  // marks the indirect pointer, held in the memory read register
    logic       rmem_cap;  // capture memory read for mode read memory
    logic       fin_out;   // form result
  } lc3s_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] opcode;
  } lc3s_stat_t;

endpackage

>>> rtl/lc3_instruction_step_unit.sv
// lc3_instruction_step_unit: top level of the lc3 instruction step unit
// depends on lc3s_pkg, lc3s_ctrl, lc3s_dp
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    mode, address, data
// out      output     out_valid / out_ready  pc, finished, cond_code, read_data
// cfg      input      cfg_we                 cfg_data (start address)
//
// one item at a time, each through idle and dispatch; write memory, write register, read
// register and unused modes end there; read memory adds a capture state, a step decode and
// mem1, loads mem2, sti mem2 and wb, ldi mem2, wb, mem2; one port for fetch and data
// reset clears registers, condition code and loads pc with 0x3000; memory is not cleared
// a waiting result holds the unit in idle until it is taken
module lc3_instruction_step_unit import lc3s_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [15:0] address,
  input  logic [15:0] data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pc,
  output logic        finished,
  output logic [2:0]  cond_code,
  output logic [15:0] read_data
);

  lc3s_cmd_t  cmd;
  lc3s_stat_t stat;

  lc3s_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  lc3s_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .mode(mode), .address(address), .data(data), .cmd(cmd),
    .stat(stat), .pc(pc), .finished(finished),
    .cond_code(cond_code), .read_data(read_data)
  );

endmodule

>>> rtl/lc3s_ctrl.sv
// lc3s_ctrl: sequencer of the lc3 instruction step unit
// depends on lc3s_pkg
module lc3s_ctrl import lc3s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lc3s_stat_t stat,
  output lc3s_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_MEM1  = 3'd3;
  localparam logic [2:0] S_MEM2  = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_RMEM  = 3'd6;

  logic [2:0] state, state_next;
  logic       out_full;
  logic       done;
  // second pass of LDI through S_MEM2 acts as a load
  logic       ldi_second;

  assign in_ready  = (state == S_IDLE) && (!out_full || out_ready);
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.mode)
          MODE_WMEM: begin
            cmd.mem_wr = 1'b1; cmd.mem_sel = MA_INPUT; cmd.wr_input = 1'b1;
            done = 1'b1;
          end
          MODE_RMEM: begin
            cmd.mem_rd = 1'b1; cmd.mem_sel = MA_INPUT;
            state_next = S_RMEM;
          end
          MODE_STEP: begin
            cmd.mem_rd = 1'b1; cmd.mem_sel = MA_PC;
            state_next = S_DEC;
          end
          default: done = 1'b1;
        endcase
      end
      S_RMEM: begin
        cmd.rmem_cap = 1'b1;
        done = 1'b1;
      end
      S_DEC: begin
        cmd.ir_load = 1'b1;
        state_next = S_MEM1;
      end
      S_MEM1: begin
        cmd.exec = 1'b1;
        unique case (stat.opcode)
          OP_LD, OP_LDR, OP_LDI: begin
            cmd.mem_rd = 1'b1; cmd.mem_sel = MA_EA;
            state_next = S_MEM2;
          end
          OP_ST, OP_STR: begin
            cmd.mem_wr = 1'b1; cmd.mem_sel = MA_EA;
            done = 1'b1;
          end
          OP_STI: begin
            cmd.mem_rd = 1'b1; cmd.mem_sel = MA_EA;
            state_next = S_MEM2;
          end
          default: done = 1'b1;
        endcase
      end
      S_MEM2: begin
        unique case (stat.opcode)
          OP_LDI: begin
            if (ldi_second) begin
              cmd.load_wb = 1'b1;
              done = 1'b1;
            end else begin
              cmd.ptr_load = 1'b1;
              state_next = S_WB;
            end
          end
          OP_STI: begin
            cmd.ptr_load = 1'b1;
            state_next = S_WB;
          end
          default: begin
            cmd.load_wb = 1'b1;
            done = 1'b1;
          end
        endcase
      end
      S_WB: begin
        if (stat.opcode == OP_LDI) begin
          cmd.mem_rd = 1'b1; cmd.mem_sel = MA_RDATA;
          state_next = S_MEM2;
          // second pass through mem2 finishes as a plain load
        end else begin
          cmd.mem_wr = 1'b1; cmd.mem_sel = MA_RDATA;
          done = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (done) begin
      cmd.fin_out = 1'b1;
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      ldi_second <= 1'b0;
    end else begin
      state <= state_next;
      if (done) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
      if (state == S_WB) ldi_second <= 1'b1;
      else if (state == S_IDLE) ldi_second <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.take |=> state == S_DISP)
    else $error("take did not start dispatch");
  assert property (@(posedge clk) disable iff (rst) !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write at once");
  assert property (@(posedge clk) disable iff (rst) out_full && !out_ready |=> out_full)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst) cmd.fin_out |=> state == S_IDLE)
    else $error("item did not end in idle");

endmodule

>>> rtl/lc3s_dp.sv
// lc3s_dp: datapath with memory, register file, pc and condition code
// depends on lc3s_pkg
module lc3s_dp import lc3s_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  mode,
  input  logic [15:0] address,
  input  logic [15:0] data,
  input  lc3s_cmd_t   cmd,
  output lc3s_stat_t  stat,
  output logic [15:0] pc,
  output logic        finished,
  output logic [2:0]  cond_code,
  output logic [15:0] read_data
);

  logic [15:0] mem [2**ADDR_BITS];
  logic [15:0] regs [8];
  logic [15:0] pcr, ir, ea, mdata, rdreg;
  logic [2:0]  ccr;
  logic [2:0]  m_mode;
  logic [15:0] m_addr, m_data;
  logic [15:0] maddr, wdata;
  logic [15:0] a, b, off9, off6, off11, alu;
  logic [15:0] pc_exec;
  logic [3:0]  op;
  logic [2:0]  dr;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) return CC_ZERO;
    else if (v[15]) return CC_NEG;
    else return CC_POS;
  endfunction

  assign op   = ir[15:12];
  assign dr   = ir[11:9];
  assign a    = regs[ir[8:6]];
  assign b    = ir[5] ? {{11{ir[4]}}, ir[4:0]} : regs[ir[2:0]];
  assign off9 = {{7{ir[8]}}, ir[8:0]};
  assign off6 = {{10{ir[5]}}, ir[5:0]};
  assign off11 = {{5{ir[10]}}, ir[10:0]};
  assign stat.mode = m_mode;
  assign stat.opcode = op;

  // pc is only updated at the end of the exec cycle; pc-relative ea adds 1 to pcr itself
  always_comb begin
    priority case (1'b1)
      (op == OP_LDR) || (op == OP_STR): ea = a + off6;
      default: ea = pcr + 16'd1 + off9;
    endcase
  end

  always_comb begin
    pc_exec = pcr + 16'd1;
    unique case (op)
      OP_BR:   if ((dr & ccr) != 3'd0) pc_exec = pcr + 16'd1 + off9;
      OP_JSR:  pc_exec = ir[11] ? pcr + 16'd1 + off11 : a;
      OP_JMP:  pc_exec = a;
      OP_TRAP: if (ir[7:0] == TRAP_HALT) pc_exec = 16'd0;
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd.mem_sel)
      MA_INPUT: maddr = m_addr;
      MA_PC:    maddr = pcr;
      MA_EA:    maddr = ea;
      default:  maddr = mdata;
    endcase
  end
  assign wdata = cmd.wr_input ? m_data : regs[dr];

  always_comb begin
    unique case (op)
      OP_ADD:  alu = a + b;
      OP_AND:  alu = a & b;
      default: alu = ~a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[maddr[ADDR_BITS-1:0]] <= wdata;
    if (cmd.mem_rd) mdata <= mem[maddr[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      m_mode <= mode;
      m_addr <= address;
      m_data <= data;
    end
    if (cmd.ir_load) ir <= mdata;
    if (cmd.take) ir <= 16'hFFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      pcr <= 16'h3000;
      ccr <= '0;
      rdreg <= '0;
      finished <= 1'b0;
    end else begin
      if (cfg_we) pcr <= cfg_data;
      else if (cmd.exec) pcr <= pc_exec;
      if (cmd.take) rdreg <= '0;
      if (m_mode == MODE_WREG && cmd.fin_out) regs[m_addr[2:0]] <= m_data;
      if (m_mode == MODE_RREG && cmd.fin_out) rdreg <= regs[m_addr[2:0]];
      if (cmd.rmem_cap) rdreg <= mdata;
      if (cmd.exec) begin
        unique case (op)
          OP_ADD, OP_AND, OP_NOT: begin
            regs[dr] <= alu;
            ccr <= cc_of(alu);
          end
          OP_JSR:  regs[7] <= pcr + 16'd1;
          OP_LEA:  regs[dr] <= pcr + 16'd1 + off9;
          default: ;
        endcase
      end
      if (cmd.load_wb) begin
        regs[dr] <= mdata;
        ccr <= cc_of(mdata);
      end
      if (cmd.fin_out) finished <= (m_mode == MODE_STEP) && (ir == 16'd0);
    end
  end

  assign pc = pcr;
  assign cond_code = ccr;
  assign read_data = rdreg;

  assert property (@(posedge clk) disable iff (rst) cmd.exec |-> m_mode == MODE_STEP)
    else $error("execute outside step");
  assert property (@(posedge clk) disable iff (rst)
    cmd.rmem_cap |=> read_data == $past(mdata))
    else $error("read data not captured");
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_wb |=> cond_code != 3'd0)
    else $error("load left condition unset");

endmodule
